@@ src/lkvc_pkg.sv @@
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants for the LRU key/value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // register indexes
    localparam logic REG_CAPACITY = 1'b0;

    // opcodes
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic clear;   // drop all entries
        logic look;    // compare request key, latch match
        logic update;  // apply the request
        logic put;     // request is a put
        logic hit;     // some cell matched
        logic evict;   // insert must drop the least recent entry
    } cell_ctl_t;

endpackage

@@ src/lru_key_value_cache_core.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache_core
// Fully associative key/value cache with least-recently-used replacement,
// built as a row of entry cells under a small sequencer.
//
// Channel   Dir  Handshake          Content
// s_axis    in   s_tvalid/s_tready  tuser: opcode; tdata: key, write value
// m_axis    out  m_tvalid/m_tready  tuser: hit; tdata: read value
// apb       in   psel/penable       capacity register at address 0
//
// Each transaction has a look step, which compares the key in every cell,
// then an update step, which ripples hit/rank/free-slot through the row and
// updates the cells. A new request can be taken in the update step (when it
// is not stalled), so the next request is accepted as the last one finishes.
// The result register holds one finished result; the update stalls while it
// is still full. Reset (and a capacity write) drops all entries at once.
// ----------------------------------------------------------------------------
module lru_key_value_cache_core #(
    parameter int ENTRIES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] lookup_key, [63:32] write_value
    input  logic [0:0]  s_tuser,   // [0] opcode
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] read_value
    output logic [0:0]  m_tuser,   // [0] hit
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (OCC_W > lkvc_pkg::CAP_W) ? OCC_W : lkvc_pkg::CAP_W;

    localparam logic REG_CAPACITY_BIT = lkvc_pkg::REG_CAPACITY;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_UPDATE
    } state_t;

    state_t                           state_reg;
    logic                             op_reg;
    logic [lkvc_pkg::KEY_W-1:0]       key_reg;
    logic [lkvc_pkg::VAL_W-1:0]       wval_reg;
    logic [lkvc_pkg::CAP_W-1:0]       cap_reg;
    logic [OCC_W-1:0]                 occ_reg;
    logic                             m_tvalid_reg;
    logic                             hit_reg;
    logic [lkvc_pkg::VAL_W-1:0]       rdata_reg;

    logic                             s_accept;
    logic                             out_free;
    logic                             do_update;
    logic                             cfg_write;
    logic [CMP_W-1:0]                 cap_ext;
    logic [CMP_W-1:0]                 occ_ext;
    logic [CMP_W-1:0]                 limit;
    logic                             full;
    logic                             hit;
    logic                             evict;
    logic [RANK_W-1:0]                found_rank;
    logic [RANK_W-1:0]                evict_rank;
    lkvc_pkg::cell_ctl_t              ctl;

    logic [ENTRIES:0]                 hit_chain;
    logic [ENTRIES:0]                 free_chain;
    logic [lkvc_pkg::VAL_W-1:0]       value_chain [ENTRIES+1];
    logic [RANK_W-1:0]                rank_chain  [ENTRIES+1];

    assign out_free  = !m_tvalid_reg || m_tready;
    assign do_update = (state_reg == ST_UPDATE) && out_free;
    assign s_tready  = (state_reg == ST_IDLE) || do_update;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_CAPACITY_BIT);

    assign pready = 1'b1;
    assign prdata = {{(32 - lkvc_pkg::CAP_W){1'b0}}, cap_reg};

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = rdata_reg;
    assign m_tuser  = hit_reg;

    // capacity clamped to 1 .. ENTRIES
    assign cap_ext = CMP_W'(cap_reg);
    assign occ_ext = CMP_W'(occ_reg);
    always_comb
    begin
        if (cap_reg == '0)
            limit = CMP_W'(1);
        else if (cap_ext > CMP_W'(ENTRIES))
            limit = CMP_W'(ENTRIES);
        else
            limit = cap_ext;
    end

    assign full       = (occ_ext >= limit) && (occ_reg != '0);
    assign hit        = hit_chain[ENTRIES];
    assign found_rank = rank_chain[ENTRIES];
    assign evict      = (op_reg == lkvc_pkg::OP_PUT) && !hit && full;
    assign evict_rank = RANK_W'(occ_reg - 1'b1);

    always_comb
    begin
        ctl.clear  = cfg_write;
        ctl.look   = (state_reg == ST_LOOK);
        ctl.update = do_update;
        ctl.put    = (op_reg == lkvc_pkg::OP_PUT);
        ctl.hit    = hit;
        ctl.evict  = evict;
    end

    assign hit_chain[0]   = 1'b0;
    assign free_chain[0]  = 1'b0;
    assign value_chain[0] = '0;
    assign rank_chain[0]  = '0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        lkvc_cell #(
            .RANK_W (RANK_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .req_key    (key_reg),
            .req_value  (wval_reg),
            .found_rank (found_rank),
            .evict_rank (evict_rank),
            .hit_in     (hit_chain[i]),
            .free_in    (free_chain[i]),
            .value_in   (value_chain[i]),
            .rank_in    (rank_chain[i]),
            .hit_out    (hit_chain[i+1]),
            .free_out   (free_chain[i+1]),
            .value_out  (value_chain[i+1]),
            .rank_out   (rank_chain[i+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            op_reg   <= s_tuser[0];
            key_reg  <= s_tdata[31:0];
            wval_reg <= s_tdata[63:32];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cap_reg      <= lkvc_pkg::CAP_RESET;
            occ_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            rdata_reg    <= '0;
            hit_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                cap_reg <= pwdata[lkvc_pkg::CAP_W-1:0];
                occ_reg <= '0;
            end
            else if (do_update && op_reg == lkvc_pkg::OP_PUT && !hit && !evict)
            begin
                occ_reg <= occ_reg + 1'b1;
            end

            if (do_update)
            begin
                rdata_reg <= (hit && op_reg == lkvc_pkg::OP_GET) ?
                             value_chain[ENTRIES] : '0;
                hit_reg   <= hit;
            end

            if (do_update)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_accept)
                        state_reg <= ST_LOOK;
                end
                ST_LOOK:
                begin
                    state_reg <= ST_UPDATE;
                end
                ST_UPDATE:
                begin
                    if (s_accept)
                        state_reg <= ST_LOOK;
                    else if (do_update)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ src/lkvc_cell.sv @@
// ----------------------------------------------------------------------------
// lkvc_cell
// One cache entry: key, value, valid mark and recency rank, with ripple
// links to its neighbors for hit, read data, matched rank and free slot.
// ----------------------------------------------------------------------------
module lkvc_cell #(
    parameter int RANK_W = 4
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  lkvc_pkg::cell_ctl_t       ctl,
    input  logic [lkvc_pkg::KEY_W-1:0] req_key,
    input  logic [lkvc_pkg::VAL_W-1:0] req_value,
    input  logic [RANK_W-1:0]         found_rank,
    input  logic [RANK_W-1:0]         evict_rank,
    input  logic                      hit_in,
    input  logic                      free_in,
    input  logic [lkvc_pkg::VAL_W-1:0] value_in,
    input  logic [RANK_W-1:0]         rank_in,
    output logic                      hit_out,
    output logic                      free_out,
    output logic [lkvc_pkg::VAL_W-1:0] value_out,
    output logic [RANK_W-1:0]         rank_out
);

    logic [lkvc_pkg::KEY_W-1:0] key_reg;
    logic [lkvc_pkg::VAL_W-1:0] value_reg;
    logic                       valid_reg;
    logic [RANK_W-1:0]          rank_reg;
    logic                       match_reg;

    logic evict_me;
    logic my_free;
    logic take;
    logic insert;

    assign insert   = ctl.put && !ctl.hit;
    assign evict_me = ctl.evict && valid_reg && (rank_reg == evict_rank);
    assign my_free  = !valid_reg || evict_me;
    assign take     = my_free && !free_in;

    assign hit_out   = hit_in | match_reg;
    assign free_out  = free_in | my_free;
    assign value_out = value_in | (match_reg ? value_reg : '0);
    assign rank_out  = rank_in | (match_reg ? rank_reg : '0);

    always_ff @(posedge clk)
    begin
        if (ctl.update && insert && take)
        begin
            key_reg   <= req_key;
            value_reg <= req_value;
        end
        else if (ctl.update && ctl.put && match_reg)
        begin
            value_reg <= req_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
            match_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
            match_reg <= 1'b0;
        end
        else if (ctl.look)
        begin
            match_reg <= valid_reg && (key_reg == req_key);
        end
        else if (ctl.update)
        begin
            match_reg <= 1'b0;
            if (ctl.hit)
            begin
                if (match_reg)
                    rank_reg <= '0;
                else if (valid_reg && rank_reg < found_rank)
                    rank_reg <= rank_reg + 1'b1;
            end
            else if (insert)
            begin
                if (take)
                begin
                    valid_reg <= 1'b1;
                    rank_reg  <= '0;
                end
                else if (evict_me)
                begin
                    valid_reg <= 1'b0;
                    rank_reg  <= '0;
                end
                else if (valid_reg)
                begin
                    rank_reg <= rank_reg + 1'b1;
                end
            end
        end
    end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LRU key/value cache core. A software model of
// the cache predicts hit and read value for every accepted request, and a
// monitor compares each result transaction against the oldest prediction.
// Directed cases cover empty lookups, extreme keys and values, updates and
// eviction order. Random traffic runs over several capacity settings and
// idle/stall mixes, plus a long receiver hold-off and a sender pause.
// ----------------------------------------------------------------------------
module testbench;

    localparam int ENTRIES = 16;

    typedef struct packed {
        logic                       hit;
        logic [lkvc_pkg::VAL_W-1:0] read_value;
    } cache_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    lru_key_value_cache_core #(.ENTRIES(ENTRIES)) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    // shadow copy of the cache
    logic [lkvc_pkg::KEY_W-1:0] shadow_keys   [ENTRIES];
    logic [lkvc_pkg::VAL_W-1:0] shadow_values [ENTRIES];
    logic                       shadow_valid  [ENTRIES];
    logic [3:0]                 shadow_rank   [ENTRIES];
    logic [4:0]                 shadow_occupancy;
    logic [lkvc_pkg::CAP_W-1:0] shadow_capacity;

    cache_result_t expected_results[$];

    int fail_count = 0;
    int requests_sent = 0;
    int hits_predicted = 0;
    int evictions_predicted = 0;
    int capacity_writes = 0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;

    logic [lkvc_pkg::KEY_W-1:0] key_pool[32];
    int                         key_pool_size = 8;

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------
    function automatic void shadow_clear();
        for (int i = 0; i < ENTRIES; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_rank[i]  = '0;
        end
        shadow_occupancy = '0;
    endfunction

    function automatic int usable_entries();
        if (shadow_capacity == 0)
            return 1;
        if (shadow_capacity > ENTRIES)
            return ENTRIES;
        return shadow_capacity;
    endfunction

    // entry idx becomes rank 0; entries more recent than it age by one
    function automatic void make_most_recent(int idx);
        logic [3:0] old_rank;
        old_rank = shadow_rank[idx];
        for (int i = 0; i < ENTRIES; i++)
            if (shadow_valid[i] && shadow_rank[i] < old_rank)
                shadow_rank[i] = shadow_rank[i] + 1'b1;
        shadow_rank[idx] = '0;
    endfunction

    function automatic cache_result_t cache_access(logic op,
                                                   logic [lkvc_pkg::KEY_W-1:0] key,
                                                   logic [lkvc_pkg::VAL_W-1:0] val);
        cache_result_t res;
        int            found;
        int            slot;
        found = -1;
        slot = -1;
        res.hit = 1'b0;
        res.read_value = '0;
        for (int i = 0; i < ENTRIES; i++)
            if (found < 0 && shadow_valid[i] && shadow_keys[i] == key)
                found = i;
        res.hit = (found >= 0);
        if (op == lkvc_pkg::OP_GET)
        begin
            if (res.hit)
            begin
                res.read_value = shadow_values[found];
                make_most_recent(found);
            end
            return res;
        end
        if (res.hit)
        begin
            shadow_values[found] = val;
            make_most_recent(found);
            return res;
        end
        if (shadow_occupancy >= usable_entries() && shadow_occupancy > 0)
        begin
            for (int i = 0; i < ENTRIES; i++)
                if (slot < 0 && shadow_valid[i] && shadow_rank[i] == shadow_occupancy - 1)
                begin
                    shadow_valid[i] = 1'b0;
                    shadow_rank[i] = '0;
                    slot = i;
                end
            shadow_occupancy = shadow_occupancy - 1'b1;
            evictions_predicted++;
        end
        slot = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (slot < 0 && !shadow_valid[i])
                slot = i;
        if (slot < 0)
            return res;
        for (int i = 0; i < ENTRIES; i++)
            if (shadow_valid[i])
                shadow_rank[i] = shadow_rank[i] + 1'b1;
        shadow_keys[slot]   = key;
        shadow_values[slot] = val;
        shadow_valid[slot]  = 1'b1;
        shadow_rank[slot]   = '0;
        shadow_occupancy    = shadow_occupancy + 1'b1;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            m_tready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cache_result_t exp_res;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result transaction: hit %0d read_value %h",
                       m_tuser[0], m_tdata);
                fail_count++;
            end
            else
            begin
                exp_res = expected_results.pop_front();
                if (m_tuser[0] !== exp_res.hit)
                begin
                    $error("hit: expected %0d, got %0d", exp_res.hit, m_tuser[0]);
                    fail_count++;
                end
                if (m_tdata !== exp_res.read_value)
                begin
                    $error("read_value: expected %h, got %h", exp_res.read_value, m_tdata);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    task automatic send_request(logic op, logic [lkvc_pkg::KEY_W-1:0] key,
                                logic [lkvc_pkg::VAL_W-1:0] val);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {val, key};
        do
            @(posedge clk);
        while (!s_tready);
        expected_results.push_back(cache_access(op, key, val));
        requests_sent++;
        if (expected_results[$].hit)
            hits_predicted++;
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_all_results();
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_transfer(logic wr, logic [2:0] addr, logic [31:0] data,
                                output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_capacity_readback();
        logic [31:0] rdata;
        apb_transfer(1'b0, {lkvc_pkg::REG_CAPACITY, 2'b00}, '0, rdata);
        if (rdata !== {27'd0, shadow_capacity})
        begin
            $error("capacity: expected %0d, got %0d", shadow_capacity, rdata);
            fail_count++;
        end
    endtask

    // bus must be idle: every expected result in
    task automatic set_capacity(logic [31:0] cap);
        logic [31:0] rdata;
        apb_transfer(1'b1, {lkvc_pkg::REG_CAPACITY, 2'b00}, cap, rdata);
        shadow_capacity = cap[lkvc_pkg::CAP_W-1:0];
        shadow_clear();
        capacity_writes++;
        check_capacity_readback();
    endtask

    function automatic logic [31:0] extreme_word();
        case ($urandom_range(3))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            default: return 32'h7FFF_FFFF;
        endcase
    endfunction

    task automatic fill_key_pool(int n);
        key_pool_size = n;
        for (int i = 0; i < n; i++)
            key_pool[i] = ($urandom_range(7) == 0) ? extreme_word() : $urandom;
    endtask

    task automatic send_random_request();
        logic                       op;
        logic [lkvc_pkg::KEY_W-1:0] key;
        logic [lkvc_pkg::VAL_W-1:0] val;
        op  = ($urandom_range(99) < 55) ? lkvc_pkg::OP_PUT : lkvc_pkg::OP_GET;
        key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(key_pool_size - 1)]
                                        : $urandom;
        val = ($urandom_range(9) == 0) ? extreme_word() : $urandom;
        send_request(op, key, val);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_reset_state_and_extremes();
        check_capacity_readback();
        send_request(lkvc_pkg::OP_GET, 32'h0000_0000, 32'h1111_1111);   // empty cache
        send_request(lkvc_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(lkvc_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(lkvc_pkg::OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(lkvc_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(lkvc_pkg::OP_GET, 32'h8000_0000, 32'h0);
        send_request(lkvc_pkg::OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_request(lkvc_pkg::OP_GET, 32'h0000_0000, 32'h0);
        send_request(lkvc_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0);
        send_request(lkvc_pkg::OP_PUT, 32'h0000_0000, 32'h1234_5678);   // update in place
        send_request(lkvc_pkg::OP_GET, 32'h0000_0000, 32'h0);
        send_request(lkvc_pkg::OP_GET, 32'h0001_2345, 32'h0);
        stop_sending();
        wait_all_results();
    endtask

    // capacity 0 behaves as a single entry
    task automatic test_capacity_zero();
        set_capacity(0);
        send_request(lkvc_pkg::OP_PUT, 32'h0000_00A1, 32'h0000_0001);
        send_request(lkvc_pkg::OP_PUT, 32'h0000_00B2, 32'h0000_0002);
        send_request(lkvc_pkg::OP_GET, 32'h0000_00A1, 32'h0);
        send_request(lkvc_pkg::OP_GET, 32'h0000_00B2, 32'h0);
        stop_sending();
        wait_all_results();
    endtask

    task automatic test_eviction_order();
        set_capacity(2);
        send_request(lkvc_pkg::OP_PUT, 32'hAAAA_0000, 32'h0000_000A);
        send_request(lkvc_pkg::OP_PUT, 32'hBBBB_0000, 32'h0000_000B);
        send_request(lkvc_pkg::OP_GET, 32'hAAAA_0000, 32'h0);          // A now most recent
        send_request(lkvc_pkg::OP_PUT, 32'hCCCC_0000, 32'h0000_000C);  // evicts B
        send_request(lkvc_pkg::OP_GET, 32'hBBBB_0000, 32'h0);
        send_request(lkvc_pkg::OP_GET, 32'hAAAA_0000, 32'h0);
        send_request(lkvc_pkg::OP_GET, 32'hCCCC_0000, 32'h0);
        stop_sending();
        wait_all_results();
    endtask

    task automatic test_random_traffic();
        int caps[10] = '{16, 1, 31, 3, 0, 8, 17, 2, 16, 5};
        int idle_modes[4][2] = '{'{0, 0}, '{82, 0}, '{0, 82}, '{24, 24}};
        for (int p = 0; p < 10; p++)
        begin
            set_capacity(caps[p]);
            send_idle_pct  = idle_modes[p % 4][0];
            recv_stall_pct = idle_modes[p % 4][1];
            fill_key_pool(usable_entries() + $urandom_range(1, 4));
            repeat (110) send_random_request();
            stop_sending();
            wait_all_results();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    // long receiver hold-off while the sender keeps offering requests
    task automatic test_receiver_hold();
        set_capacity(3);
        fill_key_pool(5);
        hold_cycles = 300;
        repeat (30) send_random_request();
        stop_sending();
        wait_all_results();
    endtask

    task automatic test_sender_pause();
        set_capacity(4);
        fill_key_pool(6);
        recv_stall_pct = 24;
        repeat (12) send_random_request();
        stop_sending();
        wait_all_results();
        repeat (12) send_random_request();
        stop_sending();
        wait_all_results();
        recv_stall_pct = 0;
    endtask

    initial
    begin
        shadow_capacity = lkvc_pkg::CAP_RESET;
        shadow_clear();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state_and_extremes();
        test_capacity_zero();
        test_eviction_order();
        test_random_traffic();
        test_receiver_hold();
        test_sender_pause();

        wait_all_results();
        repeat (20) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_results.size());
            fail_count++;
        end
        $display("Ran %0d requests over %0d capacity settings: %0d hits, %0d evictions.",
                 requests_sent, capacity_writes + 1, hits_predicted, evictions_predicted);
        $display("Included a long result hold-off, a sender pause and mixed idle/stall.");
        if (fail_count == 0)
            $display("PASS lru_key_value_cache_core");
        else
            $display("FAIL lru_key_value_cache_core");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL lru_key_value_cache_core");
        $finish;
    end

endmodule

@@ files.f @@
src/lkvc_pkg.sv
src/lkvc_cell.sv
src/lru_key_value_cache_core.sv
tb/testbench.sv
